// ===== src/assert_macros.svh =====
// Assertion helpers included by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/hsvrgb_pkg.sv =====
package hsvrgb_pkg;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Eight sections of the wheel, picked by the top three hue bits.
	typedef enum logic [2:0] {
		SEC_RED_ORANGE    = 3'd0,
		SEC_ORANGE_YELLOW = 3'd1,
		SEC_YELLOW_GREEN  = 3'd2,
		SEC_GREEN_AQUA    = 3'd3,
		SEC_AQUA_BLUE     = 3'd4,
		SEC_BLUE_PURPLE   = 3'd5,
		SEC_PURPLE_PINK   = 3'd6,
		SEC_PINK_RED      = 3'd7
	} sect_t;

	localparam logic [7:0] THIRD_SCALE      = 8'(256 / 3);
	localparam logic [7:0] TWO_THIRDS_SCALE = 8'((256 * 2) / 3);
	localparam logic [7:0] FULL_LEVEL       = 8'd255;
	localparam logic [7:0] LEVEL_171        = 8'd171;
	localparam logic [7:0] LEVEL_170        = 8'd170;
	localparam logic [7:0] LEVEL_85         = 8'd85;

	// (i * (1 + s)) >> 8; the product stays below 2^16.
	function automatic logic [7:0] scale8(input logic [7:0] i, input logic [7:0] s);
		logic [15:0] prod;
		prod = 16'(i) * (16'(s) + 16'd1);
		return prod[15:8];
	endfunction

	// ((i * s) >> 8) plus one when both inputs are nonzero.
	function automatic logic [7:0] video8(input logic [7:0] i, input logic [7:0] s);
		logic [15:0] prod;
		prod = 16'(i) * 16'(s);
		return prod[15:8] + {7'd0, (i != 8'd0) && (s != 8'd0)};
	endfunction

endpackage

// ===== src/hsv_to_rgb_rainbow_core.sv =====
// Rainbow-spectrum HSV to RGB converter, 8 bits per channel.
// Input: assert start for one cycle with a pixel on hsv; the item is taken at
// that clock edge whenever busy is low. busy is always low: a new pixel may
// be given in every cycle, so the rate is one pixel per clock.
// Output: done pulses for exactly one cycle with the converted pixel on rgb,
// once the pixel has passed through every stage below. Results leave in input order.
// Pipeline stages: (1) hue ramp, desaturation floor and squared brightness,
// (2) section select, (3) saturation scaling with floor add, (4) brightness.
// Stages 3 and 4 hold one 8x8 multiply per channel; stage 1 holds the shared ones.
// Reset clears the valid bits of every stage, so nothing is delivered for
// items in flight when arst_n falls. The receiver cannot hold results off,
// and the block never needs to stall.
`include "assert_macros.svh"

module hsv_to_rgb_rainbow_core
	import hsvrgb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  hsv_t hsv,
	output logic done,
	output rgb_t rgb
);

	// Stage 1
	logic        valid_s1;
	sect_t       sect_s1;
	logic [7:0]  one3_s1, two3_s1, floor_s1, vv_s1, sat_s1, val_s1;
	// Stage 2
	logic        valid_s2;
	logic [7:0]  r_s2, g_s2, b_s2, floor_s2, vv_s2, sat_s2, val_s2;
	// Stage 3
	logic        valid_s3;
	logic [7:0]  r_s3, g_s3, b_s3, vv_s3, val_s3;
	// Stage 4
	logic        valid_s4;
	rgb_t        rgb_s4;

	logic [7:0]  ramp;
	logic [7:0]  r_c, g_c, b_c;
	logic [7:0]  r_sat, g_sat, b_sat;
	rgb_t        rgb_c;

	assign busy = 1'b0;
	assign ramp = {hsv.hue[4:0], 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		sect_s1  <= sect_t'(hsv.hue[7:5]);
		one3_s1  <= scale8(ramp, THIRD_SCALE);
		two3_s1  <= scale8(ramp, TWO_THIRDS_SCALE);
		floor_s1 <= scale8(~hsv.saturation, ~hsv.saturation);
		vv_s1    <= video8(hsv.brightness, hsv.brightness);
		sat_s1   <= hsv.saturation;
		val_s1   <= hsv.brightness;
	end

	always_comb begin
		r_c = '0;
		g_c = '0;
		b_c = '0;
		unique case (sect_s1)
			SEC_RED_ORANGE: begin
				r_c = FULL_LEVEL - one3_s1; g_c = one3_s1;
			end
			SEC_ORANGE_YELLOW: begin
				r_c = LEVEL_171; g_c = LEVEL_85 + one3_s1;
			end
			SEC_YELLOW_GREEN: begin
				r_c = LEVEL_171 - two3_s1; g_c = LEVEL_170 + one3_s1;
			end
			SEC_GREEN_AQUA: begin
				g_c = FULL_LEVEL - one3_s1; b_c = one3_s1;
			end
			SEC_AQUA_BLUE: begin
				g_c = LEVEL_171 - two3_s1; b_c = LEVEL_85 + two3_s1;
			end
			SEC_BLUE_PURPLE: begin
				r_c = one3_s1; b_c = FULL_LEVEL - one3_s1;
			end
			SEC_PURPLE_PINK: begin
				r_c = LEVEL_85 + one3_s1; b_c = LEVEL_171 - one3_s1;
			end
			SEC_PINK_RED: begin
				r_c = LEVEL_170 + one3_s1; b_c = LEVEL_85 - one3_s1;
			end
			default: begin
				r_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		r_s2     <= r_c;
		g_s2     <= g_c;
		b_s2     <= b_c;
		floor_s2 <= floor_s1;
		vv_s2    <= vv_s1;
		sat_s2   <= sat_s1;
		val_s2   <= val_s1;
	end

	// A zero channel keeps zero before the floor is added; the sum wraps at 8 bits.
	always_comb begin
		if (sat_s2 == FULL_LEVEL) begin
			r_sat = r_s2;
			g_sat = g_s2;
			b_sat = b_s2;
		end else if (sat_s2 == 8'd0) begin
			r_sat = FULL_LEVEL;
			g_sat = FULL_LEVEL;
			b_sat = FULL_LEVEL;
		end else begin
			r_sat = ((r_s2 != 8'd0) ? scale8(r_s2, sat_s2) : 8'd0) + floor_s2;
			g_sat = ((g_s2 != 8'd0) ? scale8(g_s2, sat_s2) : 8'd0) + floor_s2;
			b_sat = ((b_s2 != 8'd0) ? scale8(b_s2, sat_s2) : 8'd0) + floor_s2;
		end
	end

	always_ff @(posedge clk) begin
		r_s3   <= r_sat;
		g_s3   <= g_sat;
		b_s3   <= b_sat;
		vv_s3  <= vv_s2;
		val_s3 <= val_s2;
	end

	always_comb begin
		if (val_s3 == FULL_LEVEL) begin
			rgb_c = '{red: r_s3, green: g_s3, blue: b_s3};
		end else begin
			// video8 already yields zero for a zero channel or a zero square.
			rgb_c.red   = video8(r_s3, vv_s3);
			rgb_c.green = video8(g_s3, vv_s3);
			rgb_c.blue  = video8(b_s3, vv_s3);
		end
	end

	always_ff @(posedge clk) begin
		rgb_s4 <= rgb_c;
	end

	assign done = valid_s4;
	assign rgb  = rgb_s4;

	`ASSERT_IMPLIES(a_done_has_item, clk, arst_n, done, $past(start, 4))
	`ASSERT_NEXT(a_black_at_zero, clk, arst_n, valid_s3 && (val_s3 == 8'd0),
		rgb == '0)
	`ASSERT_NEXT(a_white_at_zero_sat, clk, arst_n,
		valid_s3 && (val_s3 == FULL_LEVEL) && (r_s3 == FULL_LEVEL) &&
		(g_s3 == FULL_LEVEL) && (b_s3 == FULL_LEVEL),
		(rgb.red == FULL_LEVEL) && (rgb.green == FULL_LEVEL) && (rgb.blue == FULL_LEVEL))
	`ASSERT_IMPLIES(a_valid_chain, clk, arst_n, valid_s4, $past(valid_s3))

endmodule
